FILE: hdl/cfr_pkg.sv
package cfr_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] MAX_PAYLOAD = 8'd249;

  // Configuration register indexes.
  localparam logic [7:0] REG_BROADCAST_ADDRESS = 8'd0;
  localparam logic [7:0] REG_OWN_ADDRESS       = 8'd1;

  localparam logic [7:0] BROADCAST_RESET = 8'd255;
  localparam logic [7:0] OWN_RESET       = 8'd0;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] function_id;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       frame_ok;
    logic [7:0] sum_first;
    logic [7:0] sum_second;
  } out_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] data;
  } cfg_item_t;

  // Address registers handed to the deframer.
  typedef struct packed {
    logic [7:0] broadcast_address;
    logic [7:0] own_address;
  } addr_cfg_t;

endpackage

FILE: hdl/cfr_stream_if.sv
interface cfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/cfr_deframer.sv
module cfr_deframer
  import cfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  addr_cfg_t  addr_cfg_i,
  output logic       res_valid_o,
  output out_item_t  res_o
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_FUNC = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHK1 = 3'd5;
  localparam logic [2:0] PH_CHK2 = 3'd6;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] func_r, func_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sos_r, sos_nxt;
  logic [7:0] chk1_r, chk1_nxt;

  logic [7:0] sum_acc;
  logic [7:0] sos_acc;
  logic       addr_match;

  assign sum_acc    = sum_r + rx_byte_i;
  assign sos_acc    = sos_r + sum_acc;
  assign addr_match = (rx_byte_i == addr_cfg_i.broadcast_address) ||
                      (rx_byte_i == addr_cfg_i.own_address);

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    func_nxt    = func_r;
    sum_nxt     = sum_r;
    sos_nxt     = sos_r;
    chk1_nxt    = chk1_r;
    res_valid_o = 1'b0;
    res_o.is_end         = 1'b0;
    res_o.function_id    = func_r;
    res_o.byte_index     = 8'd0;
    res_o.payload_byte   = 8'd0;
    res_o.payload_length = len_r;
    res_o.frame_ok       = 1'b0;
    res_o.sum_first      = sum_r;
    res_o.sum_second     = sos_r;
    unique case (phase_r)
      PH_ADDR: begin
        if (addr_match) begin
          sum_nxt   = sum_acc;
          sos_nxt   = sos_acc;
          phase_nxt = PH_FUNC;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_FUNC: begin
        func_nxt  = rx_byte_i;
        sum_nxt   = sum_acc;
        sos_nxt   = sos_acc;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if ((rx_byte_i != 8'd0) && (rx_byte_i <= MAX_PAYLOAD)) begin
          len_nxt   = rx_byte_i;
          left_nxt  = rx_byte_i;
          pos_nxt   = 8'd0;
          sum_nxt   = sum_acc;
          sos_nxt   = sos_acc;
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DATA: begin
        sum_nxt              = sum_acc;
        sos_nxt              = sos_acc;
        res_valid_o          = 1'b1;
        res_o.byte_index     = pos_r;
        res_o.payload_byte   = rx_byte_i;
        res_o.sum_first      = sum_acc;
        res_o.sum_second     = sos_acc;
        pos_nxt              = pos_r + 8'd1;
        left_nxt             = left_r - 8'd1;
        if (left_r == 8'd1) begin
          phase_nxt = PH_CHK1;
        end
      end
      PH_CHK1: begin
        chk1_nxt  = rx_byte_i;
        phase_nxt = PH_CHK2;
      end
      PH_CHK2: begin
        res_valid_o    = 1'b1;
        res_o.is_end   = 1'b1;
        res_o.frame_ok = (chk1_r == sum_r) && (rx_byte_i == sos_r);
        phase_nxt      = PH_HUNT;
      end
      default: begin
        // The unused phase code behaves as hunting.
        if (rx_byte_i == HEADER_BYTE) begin
          sum_nxt   = rx_byte_i;
          sos_nxt   = rx_byte_i;
          left_nxt  = 8'd0;
          pos_nxt   = 8'd0;
          phase_nxt = PH_ADDR;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= 8'd0;
      pos_r   <= 8'd0;
      len_r   <= 8'd0;
      func_r  <= 8'd0;
      sum_r   <= 8'd0;
      sos_r   <= 8'd0;
      chk1_r  <= 8'd0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      func_r  <= func_nxt;
      sum_r   <= sum_nxt;
      sos_r   <= sos_nxt;
      chk1_r  <= chk1_nxt;
    end
  end

endmodule

FILE: hdl/checked_frame_receiver.sv
// Frame receiver for a byte stream of 0xAA-headed, length-prefixed frames
// protected by an 8-bit sum and an 8-bit sum of sums. Each accepted word is
// one received byte; every payload byte yields one result word and the second
// check byte yields one end-of-frame word with both computed sums and the
// match flag. Other bytes yield nothing. The block takes one byte per clock
// cycle while in_ch.ready is high: a byte goes into an input register, and
// when the output register is empty or being taken, the frame state and sums
// update and the byte's result is loaded into the output register, which
// offers it on out_ch.
// in_ch.ready drops only while both the input register and the output
// register are full and out_ch.ready is low. The configuration port is always
// ready; the address registers are compared when an address byte is
// processed, so write them only while no bytes are in flight.
module checked_frame_receiver
  import cfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cfr_stream_if.sink   in_ch,
  cfr_stream_if.source out_ch,
  cfr_stream_if.sink   cfg_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  addr_cfg_t  addr_cfg_r;

  logic       advance;
  logic       res_valid;
  out_item_t  res;
  cfg_item_t  cfg_word;
  in_item_t   in_word;

  assign cfg_word = cfg_ch.payload;
  assign in_word  = in_ch.payload;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_cfg_r.broadcast_address <= BROADCAST_RESET;
      addr_cfg_r.own_address       <= OWN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_word.index)
        REG_BROADCAST_ADDRESS: addr_cfg_r.broadcast_address <= cfg_word.data;
        REG_OWN_ADDRESS:       addr_cfg_r.own_address       <= cfg_word.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_word.rx_byte;
    end
  end

  cfr_deframer u_deframer (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .rx_byte_i   (in_byte_r),
    .addr_cfg_i  (addr_cfg_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The output word is replaced only when it is empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cfr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_OFF_AT     = 200;
  localparam int PHASE_BYTES     = 390;
  localparam int NUM_PHASES      = 5;
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_CYCLES      = 10;

  typedef enum logic [2:0] {
    HUNT, GOT_HEADER, GOT_ADDR, GOT_FUNC, IN_PAYLOAD, WAIT_CHECK1, WAIT_CHECK2
  } rx_phase_e;

  typedef enum int {FLAW_NONE, FLAW_FIRST, FLAW_SECOND, FLAW_TRUNC} flaw_e;

  class frame_scoreboard;
    logic [7:0] bcast, own;
    rx_phase_e  phase;
    logic [7:0] left, pos, dlen, func, sum1, sum2, chk1;
    out_item_t  expected_q[$];
    int         fail_count;

    function new();
      bcast = BROADCAST_RESET;
      own   = OWN_RESET;
      phase = HUNT;
      left  = '0;
      pos   = '0;
      dlen  = '0;
      func  = '0;
      sum1  = '0;
      sum2  = '0;
      chk1  = '0;
      fail_count = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == REG_BROADCAST_ADDRESS) bcast = val;
      else if (idx == REG_OWN_ADDRESS) own = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_byte(logic [7:0] b);
      sum1 = sum1 + b;
      sum2 = sum2 + sum1;
    endfunction

    function void push_result(logic is_end, logic [7:0] idx, logic [7:0] pb, logic ok);
      out_item_t r;
      r.is_end         = is_end;
      r.function_id    = func;
      r.byte_index     = idx;
      r.payload_byte   = pb;
      r.payload_length = dlen;
      r.frame_ok       = ok;
      r.sum_first      = sum1;
      r.sum_second     = sum2;
      expected_q.push_back(r);
    endfunction

    // Advances the deframer state by one accepted input word.
    function void note_byte(logic [7:0] b);
      case (phase)
        GOT_HEADER: begin
          if (b == bcast || b == own) begin
            add_byte(b);
            phase = GOT_ADDR;
          end else begin
            phase = HUNT;
          end
        end
        GOT_ADDR: begin
          func = b;
          add_byte(b);
          phase = GOT_FUNC;
        end
        GOT_FUNC: begin
          if (b >= 8'd1 && b <= MAX_PAYLOAD) begin
            dlen = b;
            left = b;
            pos  = '0;
            add_byte(b);
            phase = IN_PAYLOAD;
          end else begin
            phase = HUNT;
          end
        end
        IN_PAYLOAD: begin
          add_byte(b);
          push_result(1'b0, pos, b, 1'b0);
          pos  = pos + 8'd1;
          left = left - 8'd1;
          if (left == 8'd0) phase = WAIT_CHECK1;
        end
        WAIT_CHECK1: begin
          chk1  = b;
          phase = WAIT_CHECK2;
        end
        WAIT_CHECK2: begin
          push_result(1'b1, 8'd0, 8'd0, (chk1 == sum1) && (b == sum2));
          phase = HUNT;
        end
        default: begin
          if (b == HEADER_BYTE) begin
            sum1 = '0;
            sum2 = '0;
            add_byte(b);
            left  = '0;
            pos   = '0;
            phase = GOT_HEADER;
          end else begin
            phase = HUNT;
          end
        end
      endcase
    endfunction

    static function string show(out_item_t r);
      return $sformatf("end=%0b fn=%h idx=%0d byte=%h len=%0d ok=%0b s1=%h s2=%h",
                       r.is_end, r.function_id, r.byte_index, r.payload_byte,
                       r.payload_length, r.frame_ok, r.sum_first, r.sum_second);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.is_end !== want.is_end || got.function_id !== want.function_id ||
          got.byte_index !== want.byte_index || got.payload_byte !== want.payload_byte ||
          got.payload_length !== want.payload_length || got.frame_ok !== want.frame_ok ||
          got.sum_first !== want.sum_first || got.sum_second !== want.sum_second) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cfr_stream_if #(.payload_t(in_item_t))  in_if ();
  cfr_stream_if #(.payload_t(out_item_t)) out_if ();
  cfr_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  checked_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  frame_scoreboard sb;
  int         bytes_sent;
  int         results_seen;
  int         rx_wait;
  int         quiet_cycles;
  bit         tx_burst;
  bit         rx_burst;
  bit         held_off;
  logic [7:0] gen_s1, gen_s2;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: ready is decided at each falling edge from the pending wait count.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n || rx_wait > 0) begin
        out_if.ready <= 1'b0;
        if (rx_wait > 0) rx_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.payload);
      results_seen++;
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
      // One long hold-off so that the block backs up and stalls its input.
      if (!held_off && results_seen == HOLD_OFF_AT) begin
        held_off = 1'b1;
        rx_wait  = HOLD_OFF_CYCLES;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return sb.bcast;
    if (r < 90) return sb.own;
    return rand8();
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.payload <= in_item_t'{rx_byte: b};
    do @(posedge clk); while (!in_if.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_counted(logic [7:0] b);
    send_byte(b);
    gen_s1 = gen_s1 + b;
    gen_s2 = gen_s2 + gen_s1;
  endtask

  // A negative fill gives random payload bytes.
  task automatic send_frame(logic [7:0] addr, logic [7:0] fn, logic [7:0] len, int fill,
                            flaw_e flaw);
    int         cut;
    logic [7:0] c1, c2;
    gen_s1 = '0;
    gen_s2 = '0;
    cut = (flaw == FLAW_TRUNC) ? $urandom_range(0, len - 1) : len;
    send_counted(HEADER_BYTE);
    send_counted(addr);
    send_counted(fn);
    send_counted(len);
    for (int i = 0; i < cut; i++) send_counted((fill < 0) ? rand8() : 8'(fill));
    if (flaw == FLAW_TRUNC) return;
    c1 = gen_s1;
    c2 = gen_s2;
    if (flaw == FLAW_FIRST) c1 = c1 ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_SECOND) c2 = c2 ^ 8'($urandom_range(1, 255));
    send_byte(c1);
    send_byte(c2);
  endtask

  task automatic send_broken();
    logic [7:0] a;
    send_byte(HEADER_BYTE);
    if ($urandom_range(0, 1) == 1) begin
      do a = rand8(); while (a == sb.bcast || a == sb.own);
      send_byte(a);
    end else begin
      send_byte(($urandom_range(0, 1) == 1) ? sb.bcast : sb.own);
      send_byte(rand8());
      send_byte(($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(250, 255)));
    end
  endtask

  task automatic random_piece();
    int         r;
    logic [7:0] len;
    r   = $urandom_range(0, 99);
    len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(1, MAX_PAYLOAD))
                                       : 8'($urandom_range(1, 12));
    if (r < 70) begin
      send_frame(pick_addr(), rand8(), len, -1, FLAW_NONE);
    end else if (r < 80) begin
      if ($urandom_range(0, 1) == 1) send_frame(pick_addr(), rand8(), len, -1, FLAW_FIRST);
      else send_frame(pick_addr(), rand8(), len, -1, FLAW_SECOND);
    end else if (r < 88) begin
      send_frame(pick_addr(), rand8(), len, -1, FLAW_TRUNC);
    end else if (r < 94) begin
      send_broken();
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(($urandom_range(0, 3) == 0) ? HEADER_BYTE : rand8());
    end
  endtask

  // Stops offering words and waits until every expected word has come out,
  // then lets the pipeline settle for bytes that yield nothing.
  task automatic drain_block();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= cfg_item_t'{index: idx, data: val};
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] next_bcast, next_own;
    bit         paused;
    sb            = new();
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.payload = '0;
    bytes_sent    = 0;
    results_seen  = 0;
    rx_wait       = 0;
    quiet_cycles  = 0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    held_off      = 1'b0;
    paused        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_block();
        case (p)
          1: begin next_bcast = 8'h00; next_own = 8'hFF; end
          2: begin next_bcast = 8'hAA; next_own = 8'h55; end
          3: begin next_bcast = rand8(); next_own = rand8(); end
          default: begin next_bcast = 8'h7F; next_own = 8'h7F; end
        endcase
        if (p % 2 == 1) begin
          write_reg(REG_OWN_ADDRESS, next_own);
          write_reg(REG_BROADCAST_ADDRESS, next_bcast);
        end else begin
          write_reg(REG_BROADCAST_ADDRESS, next_bcast);
          write_reg(REG_OWN_ADDRESS, next_own);
        end
      end else begin
        // Reset addresses: broadcast and own frames with extreme payload
        // bytes, a bad first check byte, a repeated header taken as a wrong
        // address, then a zero and an oversized length.
        send_frame(8'hFF, 8'h00, 8'd1, 8'h00, FLAW_NONE);
        send_frame(8'h00, 8'hFF, 8'd1, 8'hFF, FLAW_FIRST);
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(HEADER_BYTE);
        send_byte(8'hFF);
        send_byte(8'h10);
        send_byte(8'h00);
        send_byte(HEADER_BYTE);
        send_byte(8'h00);
        send_byte(8'h10);
        send_byte(8'hFA);
      end
      while (bytes_sent < (p + 1) * PHASE_BYTES) begin
        random_piece();
        if (!paused && p == 2 && bytes_sent > 2 * PHASE_BYTES + 100) begin
          paused = 1'b1;
          drain_block();
        end
      end
    end

    drain_block();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/cfr_pkg.sv
hdl/cfr_stream_if.sv
hdl/cfr_deframer.sv
hdl/checked_frame_receiver.sv
bench/tb_top.sv
